// ----- rtl/kvpt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvpt_pkg
// Shared types, character codes and status codes for the key=value tokenizer.
// ----------------------------------------------------------------------------
package kvpt_pkg;

  // width of the internal byte position counters (8 to 32)
  localparam int OFFSET_WIDTH = 16;
  // width of the offset and length fields on the result port
  localparam int OUT_W        = 16;

  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

  // character codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_EQ  = 8'h3d;

  // register indexes of the configuration port
  localparam logic REG_PAIR_SEP = 1'b0;
  localparam logic REG_MSG_TERM = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NUL  = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  // one result beat
  typedef struct packed {
    logic [OUT_W-1:0] key_offset;
    logic [OUT_W-1:0] key_length;
    logic [OUT_W-1:0] value_offset;
    logic [OUT_W-1:0] value_length;
    logic             pair_present;
    logic             message_end;
    logic [OUT_W-1:0] end_offset;
    logic [1:0]       status;
  } result_t;

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ----- rtl/key_value_pair_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// key_value_pair_tokenizer_top
// Scans a message byte by byte and reports key=value pairs as offsets and
// lengths, plus message end and error status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in      | sink      | in_valid/in_stall | data_byte
//  out     | source    | out_valid/out_stall | key_offset .. status
//  cfg     | sink      | cfg_write        | cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; its result (if any) is
// registered into the output register, or into the skid buffer when the
// output register is held by out_stall; the scan state is a single register stage.
// A one-entry skid buffer behind the output register absorbs one result
// while out_stall is high; in_stall rises only while that buffer is full.
// Synchronous active-high reset clears the scan state, both output entries
// and loads pair_separator = newline and message_terminator = NUL.
// ----------------------------------------------------------------------------
module key_value_pair_tokenizer_top
  import kvpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data,
  // input bytes
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  // results
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] key_offset,
  output logic [OUT_W-1:0] key_length,
  output logic [OUT_W-1:0] value_offset,
  output logic [OUT_W-1:0] value_length,
  output logic             pair_present,
  output logic             message_end,
  output logic [OUT_W-1:0] end_offset,
  output logic [1:0]       status
);

  // configuration registers
  logic [7:0] pair_sep;
  logic [7:0] msg_term;

  // scan state
  logic [OFFSET_WIDTH-1:0] pos;
  logic [OFFSET_WIDTH-1:0] kstart;
  logic                    key_started;
  logic [OFFSET_WIDTH-1:0] vstart;
  logic                    eq_seen;
  logic [7:0]              prev;

  logic [OFFSET_WIDTH-1:0] pos_next;
  logic [OFFSET_WIDTH-1:0] kstart_next;
  logic                    key_started_next;
  logic [OFFSET_WIDTH-1:0] vstart_next;
  logic                    eq_seen_next;
  logic [7:0]              prev_next;

  // output register and skid buffer
  result_t out_q;
  result_t skid_q;
  logic    skid_valid;
  result_t res;
  logic    has_res;

  logic in_accept;
  logic out_take;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // byte classification
  logic term_space;
  logic last;
  logic skip;
  logic nul_err;
  logic at_max;
  logic nl_end;

  assign term_space = (msg_term != CH_NL) && is_white(msg_term);
  assign last       = (data_byte == msg_term);
  assign skip       = !term_space && !eq_seen && !last && is_white(data_byte);
  assign nul_err    = (msg_term != CH_NUL) && (data_byte == CH_NUL);
  assign at_max     = (pos >= OFFSET_MAX);
  assign nl_end     = (msg_term == CH_NL && last) || (pair_sep == CH_NL);

  // pair arithmetic
  logic [OFFSET_WIDTH-1:0] kstart_eff;
  logic [OFFSET_WIDTH-1:0] pos_inc;
  logic [OFFSET_WIDTH-1:0] klen;
  logic [OFFSET_WIDTH-1:0] vlen_raw;
  logic                    strip_cr;
  logic [OFFSET_WIDTH-1:0] vlen;

  assign kstart_eff = key_started ? kstart : pos;
  assign pos_inc    = pos + OFFSET_WIDTH'(1);
  assign klen       = vstart - OFFSET_WIDTH'(1) - kstart_eff;
  assign vlen_raw   = pos - vstart;
  assign strip_cr   = nl_end && (pos != '0) && (prev == CH_CR) && (vlen_raw != '0);
  assign vlen       = strip_cr ? vlen_raw - OFFSET_WIDTH'(1) : vlen_raw;

  // next scan state and result for the byte on the input
  always_comb begin
    logic new_msg;
    new_msg          = 1'b0;
    res              = '0;
    has_res          = 1'b0;
    pos_next         = pos;
    kstart_next      = kstart;
    key_started_next = key_started;
    vstart_next      = vstart;
    eq_seen_next     = eq_seen;
    prev_next        = prev;

    priority if (at_max) begin
      res.status = ST_LONG;
      has_res    = 1'b1;
      new_msg    = 1'b1;
    end else if (skip) begin
      pos_next  = pos_inc;
      prev_next = data_byte;
    end else begin
      kstart_next      = kstart_eff;
      key_started_next = 1'b1;
      priority if (nul_err) begin
        res.status = ST_NUL;
        has_res    = 1'b1;
        new_msg    = 1'b1;
      end else if (data_byte == CH_EQ) begin
        vstart_next  = pos_inc;
        eq_seen_next = 1'b1;
        pos_next     = pos_inc;
        prev_next    = data_byte;
      end else begin
        // pair boundary
        if (data_byte == pair_sep || last) begin
          if (eq_seen) begin
            res.key_offset   = OUT_W'(kstart_eff);
            res.key_length   = OUT_W'(klen);
            res.value_offset = OUT_W'(vstart);
            res.value_length = OUT_W'(vlen);
            res.pair_present = 1'b1;
            has_res          = 1'b1;
          end
          key_started_next = 1'b0;
          eq_seen_next     = 1'b0;
          kstart_next      = '0;
          vstart_next      = '0;
        end
        if (last) begin
          res.message_end = 1'b1;
          res.end_offset  = OUT_W'(pos_inc);
          has_res         = 1'b1;
          new_msg         = 1'b1;
        end else begin
          pos_next  = pos_inc;
          prev_next = data_byte;
        end
      end
    end

    if (new_msg) begin
      pos_next         = '0;
      kstart_next      = '0;
      key_started_next = 1'b0;
      vstart_next      = '0;
      eq_seen_next     = 1'b0;
      prev_next        = '0;
    end
  end

  // configuration and scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_sep    <= CH_NL;
      msg_term    <= CH_NUL;
      pos         <= '0;
      kstart      <= '0;
      key_started <= 1'b0;
      vstart      <= '0;
      eq_seen     <= 1'b0;
      prev        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PAIR_SEP: pair_sep <= cfg_data;
          REG_MSG_TERM: msg_term <= cfg_data;
          default:      pair_sep <= pair_sep;
        endcase
      end
      if (in_accept) begin
        pos         <= pos_next;
        kstart      <= kstart_next;
        key_started <= key_started_next;
        vstart      <= vstart_next;
        eq_seen     <= eq_seen_next;
        prev        <= prev_next;
      end
    end
  end

  // output register with skid buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_accept && has_res;
        end
      end else if (in_accept && has_res) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else begin
        out_q <= res;
      end
    end else if (in_accept && has_res) begin
      skid_q <= res;
    end
  end

  assign key_offset   = out_q.key_offset;
  assign key_length   = out_q.key_length;
  assign value_offset = out_q.value_offset;
  assign value_length = out_q.value_length;
  assign pair_present = out_q.pair_present;
  assign message_end  = out_q.message_end;
  assign end_offset   = out_q.end_offset;
  assign status       = out_q.status;

endmodule

// ----- rtl/kvpt_checker.sv -----
// ----------------------------------------------------------------------------
// kvpt_checker
// Port-level checks on the tokenizer result stream, bound to the top level.
// ----------------------------------------------------------------------------
module kvpt_checker
  import kvpt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] key_offset,
  input logic [OUT_W-1:0] key_length,
  input logic [OUT_W-1:0] value_offset,
  input logic [OUT_W-1:0] value_length,
  input logic             pair_present,
  input logic             message_end,
  input logic [OUT_W-1:0] end_offset,
  input logic [1:0]       status
);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_offset) && $stable(value_length)
      && $stable(status) && $stable(end_offset))
    else $error("result beat changed while stalled");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  // an error beat carries nothing else
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !pair_present && !message_end)
    else $error("error beat carries a pair or message end");

  // an empty beat is never shown, and absent fields read as zero
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair_present || message_end || status != ST_OK)
      && (pair_present || (key_offset == '0 && key_length == '0
          && value_offset == '0 && value_length == '0))
      && (message_end || end_offset == '0))
    else $error("malformed result beat");

endmodule

bind key_value_pair_tokenizer_top kvpt_checker u_kvpt_checker (.*);
